// ===== src/assert_macros.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define WVS_ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define WVS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`else
`define WVS_ASSERT_AT(lbl, clk, rstn, prop, msg)
`define WVS_ASSERT(lbl, prop, msg)
`endif
`endif

// ===== src/wvs_pkg.sv =====
// Types, constants and helper functions of the weighted vruntime scheduler.
package wvs_pkg;

  localparam int unsigned SLOTS_DEF = 16;
  localparam logic [7:0]  SLICE_RST = 8'd4;
  localparam logic [7:0]  SLICE_MAX = 8'hFF;
  localparam logic [31:0] TIME_MAX  = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHK,
    ST_SCAN,
    ST_EXEC
  } wvs_state_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } wvs_op_e;

  typedef struct packed {
    logic [31:0] vruntime;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [15:0] remain;
    logic [2:0]  weight;
  } wvs_entry_t;

  function automatic logic [2:0] weight_f(input logic [3:0] prio);
    logic [2:0] w;
    w = (prio < 4'd5) ? 3'(4'd6 - prio) : 3'd1;
    return w;
  endfunction

  function automatic logic [5:0] step_f(input logic [2:0] weight);
    logic [5:0] s;
    unique case (weight)
      3'd2:    s = 6'd30;
      3'd3:    s = 6'd20;
      3'd4:    s = 6'd15;
      3'd5:    s = 6'd12;
      3'd6:    s = 6'd10;
      default: s = 6'd60;
    endcase
    return s;
  endfunction

endpackage

// ===== src/wvs_if.sv =====
// Request and response channel interfaces of the scheduler.
interface wvs_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [3:0]  slot;
  logic [15:0] arrival;
  logic [15:0] burst;
  logic [3:0]  priority_req;

  modport source (output valid, op, slot, arrival, burst, priority_req, input ready);
  modport sink   (input valid, op, slot, arrival, burst, priority_req, output ready);
endinterface

interface wvs_out_if;
  logic        valid;
  logic        ready;
  logic        ran;
  logic [3:0]  running_slot;
  logic        new_pick;
  logic        finished;
  logic [31:0] time_now;
  logic [31:0] turnaround;
  logic [31:0] waiting;

  modport source (output valid, ran, running_slot, new_pick, finished, time_now, turnaround,
                  waiting, input ready);
  modport sink   (input valid, ran, running_slot, new_pick, finished, time_now, turnaround,
                  waiting, output ready);
endinterface

// ===== src/wvs_ram.sv =====
// Generic single write port RAM with registered read.
module wvs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/weighted_vruntime_scheduler.sv =====
// Top level of the weighted vruntime scheduler: sequencer, slot RAM and scan comparator.
// Load request: taken in the idle state, no response. Tick that keeps the held task: IDLE, CHK, EXEC.
// Tick with a fresh pick: IDLE, CHK, SCAN, EXEC, with the RAM scan reading one slot per cycle.
// A tick waits in its last cycle while a previous response is still unread.
// Reset (async, active low) clears slot live bits, hold, slice count, time; slice length 4.
`include "assert_macros.svh"

module weighted_vruntime_scheduler #(
  parameter int unsigned SLOTS = wvs_pkg::SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  wvs_in_if.sink     req_i,
  wvs_out_if.source  rsp_o
);
  import wvs_pkg::*;

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned EW = $bits(wvs_entry_t);
  localparam logic [CW-1:0] SCAN_END = CW'(SLOTS);

  wvs_state_e      state_q, state_d;
  logic [SLOTS-1:0] live_q, live_d;
  logic            cur_valid_q, cur_valid_d;
  logic [AW-1:0]   cur_q, cur_d;
  logic [7:0]      slice_used_q, slice_used_d;
  logic [7:0]      slice_len_q;
  logic [31:0]     time_q, time_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [AW-1:0]   rd_slot_q, rd_slot_d;
  logic            rd_vld_q, rd_vld_d;
  wvs_entry_t      best_q, best_d;
  logic [AW-1:0]   best_slot_q, best_slot_d;
  logic            found_q, found_d;
  logic            picked_q, picked_d;

  logic            out_vld_q, out_vld_d;
  logic            out_ran_q, out_ran_d;
  logic [3:0]      out_slot_q, out_slot_d;
  logic            out_pick_q, out_pick_d;
  logic            out_fin_q, out_fin_d;
  logic [31:0]     out_time_q, out_time_d;
  logic [31:0]     out_turn_q, out_turn_d;
  logic [31:0]     out_wait_q, out_wait_d;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  wvs_entry_t      ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [EW-1:0]   ram_rdata;
  wvs_entry_t      rd_ent;

  logic [7:0]      limit;
  logic            ready_c;
  logic            better_c;
  logic            exec_fire;
  logic [AW-1:0]   ld_idx;
  logic [31:0]     time_n;
  logic [15:0]     rem_n;
  logic [32:0]     vr_sum;
  logic [31:0]     vr_n;
  logic [31:0]     turn_n;

  wvs_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_ent    = wvs_entry_t'(ram_rdata);
  assign limit     = (slice_len_q == 8'd0) ? 8'd1 : slice_len_q;
  assign ready_c   = live_q[rd_slot_q] && (32'(rd_ent.arrival) <= time_q);
  assign better_c  = !found_q || (rd_ent.vruntime < best_q.vruntime) ||
                     ((rd_ent.vruntime == best_q.vruntime) && (rd_ent.arrival < best_q.arrival));
  assign exec_fire = (state_q == ST_EXEC) && (!out_vld_q || rsp_o.ready);
  assign ld_idx    = AW'(req_i.slot);

  assign time_n = (time_q == TIME_MAX) ? time_q : time_q + 32'd1;
  assign rem_n  = best_q.remain - 16'd1;
  assign vr_sum = {1'b0, best_q.vruntime} + 33'(step_f(best_q.weight));
  assign vr_n   = vr_sum[32] ? TIME_MAX : vr_sum[31:0];
  assign turn_n = time_n - 32'(best_q.arrival);

  assign req_i.ready        = (state_q == ST_IDLE);
  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.ran          = out_ran_q;
  assign rsp_o.running_slot = out_slot_q;
  assign rsp_o.new_pick     = out_pick_q;
  assign rsp_o.finished     = out_fin_q;
  assign rsp_o.time_now     = out_time_q;
  assign rsp_o.turnaround   = out_turn_q;
  assign rsp_o.waiting      = out_wait_q;

  always_comb begin
    state_d      = state_q;
    live_d       = live_q;
    cur_valid_d  = cur_valid_q;
    cur_d        = cur_q;
    slice_used_d = slice_used_q;
    time_d       = time_q;
    cnt_d        = cnt_q;
    rd_slot_d    = rd_slot_q;
    rd_vld_d     = rd_vld_q;
    best_d       = best_q;
    best_slot_d  = best_slot_q;
    found_d      = found_q;
    picked_d     = picked_q;
    out_vld_d    = out_vld_q;
    out_ran_d    = out_ran_q;
    out_slot_d   = out_slot_q;
    out_pick_d   = out_pick_q;
    out_fin_d    = out_fin_q;
    out_time_d   = out_time_q;
    out_turn_d   = out_turn_q;
    out_wait_d   = out_wait_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_raddr    = '0;

    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          if (req_i.op == OP_LOAD) begin
            if (32'(req_i.slot) < SLOTS) begin
              ram_we           = 1'b1;
              ram_waddr        = ld_idx;
              ram_wdata.vruntime = '0;
              ram_wdata.arrival  = req_i.arrival;
              ram_wdata.burst    = req_i.burst;
              ram_wdata.remain   = req_i.burst;
              ram_wdata.weight   = weight_f(req_i.priority_req);
              live_d[ld_idx]   = (req_i.burst != 16'd0);
              if (cur_valid_q && (cur_q == ld_idx)) begin
                cur_valid_d  = 1'b0;
                slice_used_d = 8'd0;
              end
            end
          end else begin
            ram_raddr = cur_q;
            rd_slot_d = cur_q;
            state_d   = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        if (cur_valid_q && (slice_used_q < limit) && ready_c) begin
          best_d      = rd_ent;
          best_slot_d = cur_q;
          found_d     = 1'b1;
          picked_d    = 1'b0;
          state_d     = ST_EXEC;
        end else begin
          found_d  = 1'b0;
          picked_d = 1'b1;
          cnt_d    = '0;
          rd_vld_d = 1'b0;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_vld_q && ready_c && better_c) begin
          best_d      = rd_ent;
          best_slot_d = rd_slot_q;
          found_d     = 1'b1;
        end
        if (cnt_q < SCAN_END) begin
          ram_raddr = cnt_q[AW-1:0];
          rd_slot_d = cnt_q[AW-1:0];
          rd_vld_d  = 1'b1;
          cnt_d     = cnt_q + CW'(1);
        end else begin
          rd_vld_d = 1'b0;
          state_d  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          time_d     = time_n;
          out_vld_d  = 1'b1;
          out_ran_d  = found_q;
          out_slot_d = found_q ? 4'(best_slot_q) : 4'd0;
          out_pick_d = found_q && picked_q;
          out_fin_d  = 1'b0;
          out_time_d = time_n;
          out_turn_d = '0;
          out_wait_d = '0;
          if (found_q) begin
            ram_we             = 1'b1;
            ram_waddr          = best_slot_q;
            ram_wdata          = best_q;
            ram_wdata.remain   = rem_n;
            ram_wdata.vruntime = vr_n;
            cur_d              = best_slot_q;
            cur_valid_d        = 1'b1;
            if (picked_q) begin
              slice_used_d = 8'd1;
            end else if (slice_used_q < SLICE_MAX) begin
              slice_used_d = slice_used_q + 8'd1;
            end
            if (rem_n == 16'd0) begin
              live_d[best_slot_q] = 1'b0;
              cur_valid_d         = 1'b0;
              slice_used_d        = 8'd0;
              out_fin_d           = 1'b1;
              out_turn_d          = turn_n;
              out_wait_d          = (turn_n >= 32'(best_q.burst)) ?
                                    turn_n - 32'(best_q.burst) : 32'd0;
            end
          end else begin
            cur_valid_d  = 1'b0;
            slice_used_d = 8'd0;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q       <= '0;
      cur_valid_q  <= 1'b0;
      cur_q        <= '0;
      slice_used_q <= 8'd0;
      slice_len_q  <= SLICE_RST;
      time_q       <= '0;
      cnt_q        <= '0;
      rd_vld_q     <= 1'b0;
      found_q      <= 1'b0;
      picked_q     <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      live_q       <= live_d;
      cur_valid_q  <= cur_valid_d;
      cur_q        <= cur_d;
      slice_used_q <= slice_used_d;
      time_q       <= time_d;
      cnt_q        <= cnt_d;
      rd_vld_q     <= rd_vld_d;
      found_q      <= found_d;
      picked_q     <= picked_d;
      out_vld_q    <= out_vld_d;
      if (cfg_we_i) begin
        slice_len_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_slot_q   <= rd_slot_d;
    best_q      <= best_d;
    best_slot_q <= best_slot_d;
    out_ran_q   <= out_ran_d;
    out_slot_q  <= out_slot_d;
    out_pick_q  <= out_pick_d;
    out_fin_q   <= out_fin_d;
    out_time_q  <= out_time_d;
    out_turn_q  <= out_turn_d;
    out_wait_q  <= out_wait_d;
  end

  `WVS_ASSERT(a_fire_sets_rsp, exec_fire |=> out_vld_q, "response not posted after tick")
  `WVS_ASSERT(a_fin_ran, (out_vld_q && out_fin_q) |-> out_ran_q, "finish without a run")
  `WVS_ASSERT(a_hold_live, cur_valid_q |-> live_q[cur_q], "held slot has no work left")
  `WVS_ASSERT(a_time_step, exec_fire && !(&time_q) |=> time_q == $past(time_q) + 1, "time stuck")

endmodule
